### hw/rtl/tbpq_pkg.sv
// Shared types and codes of the transmit buffer pool queue.
// Used by the datapath, the controller, the top level and the checker.
package tbpq_pkg;

  typedef struct packed {
    logic       func;
    logic [7:0] data_byte;
    logic       last_byte;
  } in_word_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] tx_byte;
    logic       tx_last;
    logic [2:0] free_buffers;
  } out_word_t;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_TX    = 1'b1;

  localparam logic [2:0] ST_STORED  = 3'd0;
  localparam logic [2:0] ST_NOBUF   = 3'd1;
  localparam logic [2:0] ST_OVERLEN = 3'd2;
  localparam logic [2:0] ST_SENT    = 3'd3;
  localparam logic [2:0] ST_IDLE    = 3'd4;

  localparam logic [1:0] FILL_IDLE = 2'd0;
  localparam logic [1:0] FILL_ON   = 2'd1;
  localparam logic [1:0] FILL_DROP = 2'd2;

  typedef struct packed {
    logic load_in;
    logic exec;
    logic load_byte;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic need_fetch;
  } dp_stat_t;

endpackage

### hw/rtl/tbpq_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
module tbpq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/tbpq_datapath.sv
// Datapath: free list, full queue, message lengths, fill and send pointers.
// Depends on tbpq_pkg and tbpq_ram.
module tbpq_datapath
  import tbpq_pkg::*;
#(
  parameter int BUFFER_COUNT = 5,
  parameter int BUFFER_BYTES = 1024
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  ctrl_cmd_t cmd_i,
  output dp_stat_t  stat_o,
  input  in_word_t  in_data_i,
  output out_word_t out_data_o
);

  localparam int IW = (BUFFER_COUNT > 1) ? $clog2(BUFFER_COUNT) : 1;
  localparam int CW = $clog2(BUFFER_COUNT + 1);
  localparam int SW = CW + 1;
  localparam int PW = $clog2(BUFFER_BYTES + 1);
  localparam int DEPTH = BUFFER_COUNT * BUFFER_BYTES;
  localparam int AW = $clog2(DEPTH);
  localparam logic [AW-1:0] BYTES_A = AW'(BUFFER_BYTES);
  localparam logic [PW-1:0] BYTES_P = PW'(BUFFER_BYTES);
  localparam logic [CW-1:0] COUNT_C = CW'(BUFFER_COUNT);

  function automatic logic [IW-1:0] wrap(input logic [IW-1:0] h, input logic [CW-1:0] c);
    logic [SW-1:0] s;
    s = SW'(h) + SW'(c);
    if (s >= SW'(BUFFER_COUNT)) begin
      s = s - SW'(BUFFER_COUNT);
    end
    return s[IW-1:0];
  endfunction

  in_word_t      in_q;
  out_word_t     res_q, res_d, out_q;
  logic [IW-1:0] free_fifo_q [BUFFER_COUNT];
  logic [IW-1:0] free_fifo_d [BUFFER_COUNT];
  logic [IW-1:0] full_fifo_q [BUFFER_COUNT];
  logic [IW-1:0] full_fifo_d [BUFFER_COUNT];
  logic [PW-1:0] len_q [BUFFER_COUNT];
  logic [IW-1:0] free_head_q, free_head_d, full_head_q, full_head_d;
  logic [CW-1:0] free_cnt_q, free_cnt_d, full_cnt_q, full_cnt_d;
  logic [IW-1:0] send_idx_q, send_idx_d, fill_idx_q, fill_idx_d;
  logic          send_vld_q, send_vld_d;
  logic [PW-1:0] rd_ptr_q, rd_ptr_d, wr_ptr_q, wr_ptr_d;
  logic [1:0]    fill_st_q, fill_st_d;
  logic [PW-1:0] len_cur, rd_next;
  logic          len_we;
  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [7:0]    ram_rdata;
  logic [CW+2:0] free_ext;

  assign stat_o.need_fetch = (in_q.func == FUNC_TX) && send_vld_q;
  assign len_cur = len_q[send_idx_q];
  assign rd_next = rd_ptr_q + PW'(1);

  always_comb begin
    free_fifo_d = free_fifo_q;
    full_fifo_d = full_fifo_q;
    free_head_d = free_head_q;
    full_head_d = full_head_q;
    free_cnt_d  = free_cnt_q;
    full_cnt_d  = full_cnt_q;
    send_idx_d  = send_idx_q;
    send_vld_d  = send_vld_q;
    rd_ptr_d    = rd_ptr_q;
    wr_ptr_d    = wr_ptr_q;
    fill_idx_d  = fill_idx_q;
    fill_st_d   = fill_st_q;
    len_we      = 1'b0;
    ram_we      = 1'b0;
    ram_addr    = AW'(send_idx_q) * BYTES_A + AW'(rd_ptr_q);
    res_d       = '0;
    if (in_q.func == FUNC_WRITE) begin
      if (fill_st_q != FILL_ON && fill_st_q != FILL_DROP) begin
        if (free_cnt_q == '0) begin
          fill_st_d = FILL_DROP;
        end else begin
          fill_idx_d  = free_fifo_q[free_head_q];
          free_head_d = wrap(free_head_q, CW'(1));
          free_cnt_d  = free_cnt_q - CW'(1);
          fill_st_d   = FILL_ON;
          wr_ptr_d    = '0;
        end
      end
      if (fill_st_d == FILL_DROP) begin
        res_d.status = ST_NOBUF;
        if (in_q.last_byte) begin
          fill_st_d = FILL_IDLE;
        end
      end else begin
        if (wr_ptr_d < BYTES_P) begin
          ram_we       = 1'b1;
          ram_addr     = AW'(fill_idx_d) * BYTES_A + AW'(wr_ptr_d);
          wr_ptr_d     = wr_ptr_d + PW'(1);
          res_d.status = ST_STORED;
        end else begin
          res_d.status = ST_OVERLEN;
        end
        if (in_q.last_byte) begin
          len_we = 1'b1;
          if (!send_vld_q) begin
            send_idx_d = fill_idx_d;
            send_vld_d = 1'b1;
            rd_ptr_d   = '0;
          end else if (full_cnt_q < COUNT_C) begin
            full_fifo_d[wrap(full_head_q, full_cnt_q)] = fill_idx_d;
            full_cnt_d = full_cnt_q + CW'(1);
          end
          fill_st_d = FILL_IDLE;
        end
      end
    end else if (send_vld_q) begin
      res_d.status = ST_SENT;
      if (rd_next >= len_cur) begin
        res_d.tx_last = 1'b1;
        if (free_cnt_q < COUNT_C) begin
          free_fifo_d[wrap(free_head_q, free_cnt_q)] = send_idx_q;
          free_cnt_d = free_cnt_q + CW'(1);
        end
        rd_ptr_d = '0;
        if (full_cnt_q != '0) begin
          send_idx_d  = full_fifo_q[full_head_q];
          full_head_d = wrap(full_head_q, CW'(1));
          full_cnt_d  = full_cnt_q - CW'(1);
        end else begin
          send_vld_d = 1'b0;
        end
      end else begin
        rd_ptr_d = rd_next;
      end
    end else begin
      res_d.status = ST_IDLE;
    end
    free_ext = {3'b000, free_cnt_d};
    res_d.free_buffers = free_ext[2:0];
  end

  tbpq_ram #(
    .WIDTH(8),
    .DEPTH(DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we && cmd_i.exec),
    .addr_i (ram_addr),
    .wdata_i(in_q.data_byte),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < BUFFER_COUNT; i++) begin
        free_fifo_q[i] <= IW'(i);
        full_fifo_q[i] <= '0;
      end
      free_head_q <= '0;
      full_head_q <= '0;
      free_cnt_q  <= COUNT_C;
      full_cnt_q  <= '0;
      send_idx_q  <= '0;
      send_vld_q  <= 1'b0;
      rd_ptr_q    <= '0;
      wr_ptr_q    <= '0;
      fill_idx_q  <= '0;
      fill_st_q   <= FILL_IDLE;
    end else if (cmd_i.exec) begin
      free_fifo_q <= free_fifo_d;
      full_fifo_q <= full_fifo_d;
      free_head_q <= free_head_d;
      full_head_q <= full_head_d;
      free_cnt_q  <= free_cnt_d;
      full_cnt_q  <= full_cnt_d;
      send_idx_q  <= send_idx_d;
      send_vld_q  <= send_vld_d;
      rd_ptr_q    <= rd_ptr_d;
      wr_ptr_q    <= wr_ptr_d;
      fill_idx_q  <= fill_idx_d;
      fill_st_q   <= fill_st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      in_q <= in_data_i;
    end
    if (cmd_i.exec && len_we) begin
      len_q[fill_idx_d] <= wr_ptr_d;
    end
    if (cmd_i.exec) begin
      res_q <= res_d;
    end else if (cmd_i.load_byte) begin
      res_q.tx_byte <= ram_rdata;
    end
    if (cmd_i.load_out) begin
      out_q <= res_q;
    end
  end

  assign out_data_o = out_q;

endmodule

### hw/rtl/tbpq_ctrl.sv
// Controller: sequences accept, execute, store fetch and result hand-off.
// Depends on tbpq_pkg.
module tbpq_ctrl
  import tbpq_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  dp_stat_t  stat_i,
  output ctrl_cmd_t cmd_o
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_EXEC  = 2'd1;
  localparam logic [1:0] S_FETCH = 2'd2;
  localparam logic [1:0] S_EMIT  = 2'd3;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       slot_free;

  assign in_ready_o = (state_q == S_IDLE);
  assign slot_free  = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = stat_i.need_fetch ? S_FETCH : S_EMIT;
      end
      S_FETCH: begin
        cmd_o.load_byte = 1'b1;
        state_d         = S_EMIT;
      end
      S_EMIT: begin
        if (slot_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

### hw/rtl/tx_buffer_pool_queue.sv
// Transmit buffer pool queue. A write word stores one message byte into a pool of
// BUFFER_COUNT buffers of BUFFER_BYTES bytes (taken from a free list on the first
// byte, queued for sending on the last); a transmit word sends one byte of the current
// message and returns its buffer after the last byte. Every input word yields exactly
// one result word. For a write word or an idle transmit word, the result passes the execute
// and hand-off states; a sending transmit word also passes a fetch state between them
// for the registered read of the message store RAM. One word is in work at a time, so
// the next word is accepted only after the last one is handed off to the output.
// The result sits in an output register, so the next word is accepted while a result
// waits; that word then holds in its hand-off state until the output register frees.
// No clearing pass is needed after reset.
// Depends on tbpq_pkg, tbpq_ctrl and tbpq_datapath.
module tx_buffer_pool_queue
  import tbpq_pkg::*;
#(
  parameter int BUFFER_COUNT = 5,
  parameter int BUFFER_BYTES = 1024
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_word_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_data_o
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  tbpq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  tbpq_datapath #(
    .BUFFER_COUNT(BUFFER_COUNT),
    .BUFFER_BYTES(BUFFER_BYTES)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .stat_o    (stat),
    .in_data_i (in_data_i),
    .out_data_o(out_data_o)
  );

endmodule

### hw/rtl/tbpq_checker.sv
// Port-level checker for the transmit buffer pool queue, bound to the top level.
// Depends on tbpq_pkg.
module tbpq_checker
  import tbpq_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_word_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("Result word changed while stalled.");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("Input accepted while a word was in work.");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.status == ST_STORED || out_data_o.status == ST_NOBUF ||
      out_data_o.status == ST_OVERLEN || out_data_o.status == ST_SENT ||
      out_data_o.status == ST_IDLE)
    else $error("Result status out of range.");

  a_tx_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != ST_SENT |->
      out_data_o.tx_byte == 8'd0 && !out_data_o.tx_last)
    else $error("Transmit fields set on a word that sent nothing.");

endmodule

bind tx_buffer_pool_queue tbpq_checker u_tbpq_checker (.*);
